// ===== design/mgrt_pkg.sv =====
// shared constants, codes and control types for the multicast group table
package mgrt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // action codes, anything else behaves as a query
  localparam logic [1:0] ACT_JOIN  = 2'd0;
  localparam logic [1:0] ACT_DROP  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/multicast_group_refcount_table_unit.sv =====
// top level of the multicast group reference count table
//
//  channel   signals                                     direction
//  in        in_valid/in_ready, action, group_addr,      request in
//            join_granted
//  out       out_valid/out_ready, ok, ref_count,          result out
//            join_request, leave_request, table_full
//
// each request is accepted, then scanned with one registered memory read per
// entry and one compare stage, then an update step. a new request is taken
// while the previous result still waits in the output register; the update
// then holds until that result is taken. reset clears the entry valid bits at
// once, no clearing pass.
module multicast_group_refcount_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] group_addr,
  input  logic        join_granted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] ref_count,
  output logic        join_request,
  output logic        leave_request,
  output logic        table_full
);

  mgrt_pkg::cmd_t  cmd;
  mgrt_pkg::stat_t stat;

  // sequencing
  mgrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and result
  mgrt_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .group_addr    (group_addr),
    .join_granted  (join_granted),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .ref_count     (ref_count),
    .join_request  (join_request),
    .leave_request (leave_request),
    .table_full    (table_full)
  );

  // no result can appear the cycle after a request is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised right after accept");

  // a full table never requests a join and never succeeds
  a_full_fails: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (!ok && !join_request && ref_count == 32'd0))
    else $error("table_full with inconsistent fields");

  // a leave request always reports a zero count
  a_leave_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && leave_request) |-> (ok && ref_count == 32'd0 && !join_request))
    else $error("leave_request with nonzero count");

  // a granted first join stores count one
  a_join_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && join_request && ok) |-> (ref_count == 32'd1))
    else $error("granted join without count one");

endmodule

// ===== design/mgrt_ctrl.sv =====
// controller: sequences accept, table scan and update of one request
module mgrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mgrt_pkg::stat_t stat,
  output mgrt_pkg::cmd_t  cmd
);

  mgrt_pkg::state_t state, state_next;

  // handshake and commands
  assign in_ready   = (state == mgrt_pkg::ST_IDLE);
  assign cmd.start  = in_valid && in_ready;
  assign cmd.commit = (state == mgrt_pkg::ST_UPDATE) && !stat.out_busy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mgrt_pkg::ST_IDLE: begin
        if (cmd.start) state_next = mgrt_pkg::ST_SCAN;
      end
      mgrt_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = mgrt_pkg::ST_UPDATE;
      end
      mgrt_pkg::ST_UPDATE: begin
        if (cmd.commit) state_next = mgrt_pkg::ST_IDLE;
      end
      default: begin
        state_next = mgrt_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mgrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/mgrt_dpath.sv =====
// datapath: entry store, scan pipeline, update logic and result register
module mgrt_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  mgrt_pkg::cmd_t         cmd,
  output mgrt_pkg::stat_t        stat,
  input  logic [1:0]             action,
  input  logic [31:0]            group_addr,
  input  logic                   join_granted,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   ok,
  output logic [31:0]            ref_count,
  output logic                   join_request,
  output logic                   leave_request,
  output logic                   table_full
);

  localparam logic [mgrt_pkg::IDX_W-1:0] LAST_IDX =
    mgrt_pkg::IDX_W'(mgrt_pkg::TABLE_DEPTH - 1);
  localparam logic [mgrt_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [mgrt_pkg::COUNT_WIDTH-1:0] COUNT_ONE =
    mgrt_pkg::COUNT_WIDTH'(1);

  // captured request
  logic [1:0]  act;
  logic [31:0] addr;
  logic        granted;

  // entry store
  logic [mgrt_pkg::TABLE_DEPTH-1:0] valid;
  logic [31:0]                      mem_group [mgrt_pkg::TABLE_DEPTH];
  logic [mgrt_pkg::COUNT_WIDTH-1:0] mem_count [mgrt_pkg::TABLE_DEPTH];
  logic [31:0]                      q_group;
  logic [mgrt_pkg::COUNT_WIDTH-1:0] q_count;

  // scan pipeline
  logic [mgrt_pkg::IDX_W-1:0] rd_idx, idx_q, found_idx, free_idx;
  logic                       issuing, pipe_v, found, have_free;
  logic [mgrt_pkg::COUNT_WIDTH-1:0] found_cnt;

  // update decisions
  logic                             we_group, we_count, set_v, clr_v;
  logic [mgrt_pkg::IDX_W-1:0]       widx;
  logic [mgrt_pkg::COUNT_WIDTH-1:0] wcnt, res_cnt;
  logic                             res_ok, res_jreq, res_lreq, res_full;

  assign stat.scan_done = pipe_v && (idx_q == LAST_IDX);
  assign stat.out_busy  = out_valid && !out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act     <= action;
      addr    <= group_addr;
      granted <= join_granted;
    end
  end

  // read address sequencer and pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      issuing <= 1'b0;
      pipe_v  <= 1'b0;
    end else if (cmd.start) begin
      rd_idx  <= '0;
      issuing <= 1'b1;
      pipe_v  <= 1'b0;
    end else begin
      pipe_v <= issuing;
      if (issuing) begin
        rd_idx <= mgrt_pkg::IDX_W'(rd_idx + 1'b1);
        if (rd_idx == LAST_IDX) issuing <= 1'b0;
      end
    end
  end

  // entry memory, registered read at the scan address
  always_ff @(posedge clk) begin
    if (we_group) mem_group[widx] <= addr;
    if (we_count) mem_count[widx] <= wcnt;
    q_group <= mem_group[rd_idx];
    q_count <= mem_count[rd_idx];
    idx_q   <= rd_idx;
  end

  // match and free-slot search, lowest index wins
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.start) begin
      found     <= 1'b0;
      have_free <= 1'b0;
    end else if (pipe_v) begin
      if (valid[idx_q] && (q_group == addr) && !found) begin
        found     <= 1'b1;
        found_idx <= idx_q;
        found_cnt <= q_count;
      end
      if (!valid[idx_q] && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= idx_q;
      end
    end
  end

  // update and result decision
  always_comb begin
    we_group = 1'b0;
    we_count = 1'b0;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    widx     = found_idx;
    wcnt     = found_cnt;
    res_ok   = 1'b1;
    res_cnt  = '0;
    res_jreq = 1'b0;
    res_lreq = 1'b0;
    res_full = 1'b0;
    case (act)
      mgrt_pkg::ACT_JOIN: begin
        if (found) begin
          if (found_cnt != COUNT_MAX) begin
            wcnt     = mgrt_pkg::COUNT_WIDTH'(found_cnt + 1'b1);
            we_count = 1'b1;
          end else begin
            res_ok = 1'b0;
          end
          res_cnt = wcnt;
        end else if (!have_free) begin
          res_ok   = 1'b0;
          res_full = 1'b1;
        end else begin
          res_jreq = 1'b1;
          widx     = free_idx;
          wcnt     = COUNT_ONE;
          if (granted) begin
            we_group = 1'b1;
            we_count = 1'b1;
            set_v    = 1'b1;
            res_cnt  = COUNT_ONE;
          end else begin
            res_ok = 1'b0;
          end
        end
      end
      mgrt_pkg::ACT_DROP: begin
        if (found) begin
          if (found_cnt != '0) wcnt = mgrt_pkg::COUNT_WIDTH'(found_cnt - 1'b1);
          we_count = 1'b1;
          res_cnt  = wcnt;
          if (wcnt == '0) begin
            res_lreq = 1'b1;
            clr_v    = 1'b1;
          end
        end
      end
      default: begin
        if (found) res_cnt = found_cnt;
      end
    endcase
    if (!cmd.commit) begin
      we_group = 1'b0;
      we_count = 1'b0;
      set_v    = 1'b0;
      clr_v    = 1'b0;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (set_v) valid[widx] <= 1'b1;
      if (clr_v) valid[widx] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok            <= res_ok;
      ref_count     <= 32'(res_cnt);
      join_request  <= res_jreq;
      leave_request <= res_lreq;
      table_full    <= res_full;
    end
  end

endmodule

// ===== bench/mgrt_checker.sv =====
// checker for the multicast group table: tracks the table, predicts each result and compares
module mgrt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] group_addr,
  input  logic        join_granted,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        ok,
  input  logic [31:0] ref_count,
  input  logic        join_request,
  input  logic        leave_request,
  input  logic        table_full,
  output int unsigned replies_due,
  output int unsigned mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [31:0] ref_count;
    logic        join_request;
    logic        leave_request;
    logic        table_full;
  } grp_reply_t;

  // shadow copy of the group table
  logic                             slot_used [mgrt_pkg::TABLE_DEPTH];
  logic [31:0]                      slot_addr [mgrt_pkg::TABLE_DEPTH];
  logic [mgrt_pkg::COUNT_WIDTH-1:0] slot_cnt  [mgrt_pkg::TABLE_DEPTH];

  // replies owed by the block, oldest first
  grp_reply_t reply_q [$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s is %0h, should be %0h", field, seen, want));
  endtask

  // apply one request to the shadow table and return the reply it earns
  function automatic grp_reply_t table_apply(input logic [1:0] act,
                                             input logic [31:0] addr,
                                             input logic grant);
    grp_reply_t r;
    int         hit;
    int         free_slot;
    int         i;
    r         = '0;
    r.ok      = 1'b1;
    hit       = -1;
    free_slot = -1;
    // lowest matching entry and lowest free entry
    for (i = 0; i < mgrt_pkg::TABLE_DEPTH; i++) begin
      if (hit < 0 && slot_used[i] && slot_addr[i] == addr) hit = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    case (act)
      mgrt_pkg::ACT_JOIN: begin
        if (hit >= 0) begin
          // known group: count up unless saturated
          if (slot_cnt[hit] != '1) slot_cnt[hit] = slot_cnt[hit] + 1'b1;
          else r.ok = 1'b0;
          r.ref_count = 32'(slot_cnt[hit]);
        end else if (free_slot < 0) begin
          r.ok         = 1'b0;
          r.table_full = 1'b1;
        end else begin
          // new group: membership asked for, stored only if granted
          r.join_request = 1'b1;
          if (grant) begin
            slot_used[free_slot] = 1'b1;
            slot_addr[free_slot] = addr;
            slot_cnt[free_slot]  = mgrt_pkg::COUNT_WIDTH'(1);
            r.ref_count          = 32'd1;
          end else begin
            r.ok = 1'b0;
          end
        end
      end
      mgrt_pkg::ACT_DROP: begin
        if (hit >= 0) begin
          if (slot_cnt[hit] != '0) slot_cnt[hit] = slot_cnt[hit] - 1'b1;
          r.ref_count = 32'(slot_cnt[hit]);
          if (slot_cnt[hit] == '0) begin
            r.leave_request = 1'b1;
            slot_used[hit]  = 1'b0;
          end
        end
      end
      default: begin
        // query, and the spare code behaves the same
        if (hit >= 0) r.ref_count = 32'(slot_cnt[hit]);
      end
    endcase
    return r;
  endfunction

  // watch both channels on every edge
  always @(posedge clk) begin : watch
    grp_reply_t want;
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      reply_q.delete();
    end else begin
      // results first, so a stray result never meets this edge's request
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = reply_q.pop_front();
          check_field("ok", 32'(ok), 32'(want.ok));
          check_field("ref_count", ref_count, want.ref_count);
          check_field("join_request", 32'(join_request), 32'(want.join_request));
          check_field("leave_request", 32'(leave_request), 32'(want.leave_request));
          check_field("table_full", 32'(table_full), 32'(want.table_full));
        end
      end
      if (in_valid && in_ready)
        reply_q.insert(reply_q.size(), table_apply(action, group_addr, join_granted));
    end
    replies_due <= reply_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// testbench top: clock, reset, request stimulus, result stalls and the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // spare action code, handled as a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int RAND_REQS   = 1725;
  localparam int CALM_REQS   = 150;
  localparam int PHASE_LEN   = 150;
  localparam int DRAIN_EVERY = 500;
  localparam int POOL_SIZE   = 24;
  localparam int TAIL_CYCLES = 40;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  action       = mgrt_pkg::ACT_QUERY;
  logic [31:0] group_addr   = '0;
  logic        join_granted = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        ok;
  logic [31:0] ref_count;
  logic        join_request;
  logic        leave_request;
  logic        table_full;

  logic        calm = 1'b0;
  int unsigned replies_due;
  int unsigned mismatches;
  logic [31:0] group_pool [POOL_SIZE];

  multicast_group_refcount_table_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .group_addr    (group_addr),
    .join_granted  (join_granted),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .ref_count     (ref_count),
    .join_request  (join_request),
    .leave_request (leave_request),
    .table_full    (table_full)
  );

  mgrt_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .group_addr    (group_addr),
    .join_granted  (join_granted),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .ref_count     (ref_count),
    .join_request  (join_request),
    .leave_request (leave_request),
    .table_full    (table_full),
    .replies_due   (replies_due),
    .mismatches    (mismatches)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // present one request, optionally after an idle burst, and wait for its accept
  task automatic send_req(input logic [1:0] act, input logic [31:0] addr,
                          input logic grant);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    group_addr   <= addr;
    join_granted <= grant;
    // ready is settled mid cycle, so the accept happens at the next edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  // result side: ready bursts and stall bursts, no stalls once calm
  initial begin : sink_side
    int unsigned span;
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        span = $urandom_range(1, 30);
        out_ready <= 1'b1;
      end else begin
        span = $urandom_range(1, 9);
        out_ready <= 1'b0;
      end
      repeat (span) @(posedge clk);
    end
  end

  // request stimulus and verdict
  initial begin : source_side
    int unsigned roll;
    int          n;
    int          i;
    logic [1:0]  act;
    logic [31:0] addr;
    logic        join_heavy;

    foreach (group_pool[k]) group_pool[k] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // absent group: query and drop
    send_req(mgrt_pkg::ACT_QUERY, 32'h0000_0000, 1'b0);
    send_req(mgrt_pkg::ACT_DROP,  32'h0000_0000, 1'b1);
    // new groups at the address extremes, then a repeat join
    send_req(mgrt_pkg::ACT_JOIN,  32'h0000_0000, 1'b1);
    send_req(mgrt_pkg::ACT_JOIN,  32'hFFFF_FFFF, 1'b1);
    send_req(mgrt_pkg::ACT_JOIN,  32'hFFFF_FFFF, 1'b0);
    send_req(mgrt_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1'b0);
    send_req(ACT_SPARE,           32'hFFFF_FFFF, 1'b1);
    // last member leaves
    send_req(mgrt_pkg::ACT_DROP,  32'h0000_0000, 1'b0);
    // membership join refused from outside
    send_req(mgrt_pkg::ACT_JOIN,  32'hE000_0001, 1'b0);
    send_req(mgrt_pkg::ACT_DROP,  32'hFFFF_FFFF, 1'b1);
    // fill every free entry, then a new group finds the table full
    for (i = 0; i < mgrt_pkg::TABLE_DEPTH - 1; i++)
      send_req(mgrt_pkg::ACT_JOIN, 32'hE000_0100 + 32'(i), 1'b1);
    send_req(mgrt_pkg::ACT_JOIN,  32'hEFFF_FFFF, 1'b1);
    drain_results();

    // random part: alternating join heavy and drop heavy phases over a small pool
    for (n = 0; n < RAND_REQS; n++) begin
      if (n == RAND_REQS - CALM_REQS) calm <= 1'b1;
      if (n > 0 && n % DRAIN_EVERY == 0) drain_results();
      join_heavy = ((n / PHASE_LEN) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < (join_heavy ? 60 : 25)) act = mgrt_pkg::ACT_JOIN;
      else if (roll < 85)                act = mgrt_pkg::ACT_DROP;
      else if (roll < 97)                act = mgrt_pkg::ACT_QUERY;
      else                               act = ACT_SPARE;
      if ($urandom_range(0, 99) < 8) addr = $urandom;
      else                           addr = group_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_req(act, addr, $urandom_range(0, 9) < 8);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/mgrt_pkg.sv
design/mgrt_ctrl.sv
design/mgrt_dpath.sv
design/multicast_group_refcount_table_unit.sv
bench/mgrt_checker.sv
bench/tb.sv
